@@ rtl/hkcm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hkcm_pkg
// types, codes and the chord compare shared by the hotkey chain matcher
// ----------------------------------------------------------------------------
package hkcm_pkg;

    // table geometry, tied to the widths of the slot, step and alt fields
    localparam int SLOTS     = 16;
    localparam int MAX_STEPS = 4;
    localparam int MAX_ALTS  = 4;

    localparam logic [15:0] ANY_MODS = 16'h8000;

    localparam logic [1:0] KIND_CHORD = 2'd0;
    localparam logic [1:0] KIND_INFO  = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;
    localparam logic [1:0] KIND_ABORT = 2'd3;

    localparam logic [7:0] CFG_ABORT_TYPE = 8'd0;
    localparam logic [7:0] CFG_ABORT_KEY  = 8'd1;
    localparam logic [7:0] CFG_ABORT_BTN  = 8'd2;
    localparam logic [7:0] CFG_ABORT_MODS = 8'd3;

    typedef struct packed {
        logic [15:0] mods;
        logic [7:0]  button;
        logic [31:0] key;
        logic [7:0]  etype;
    } t_word;

    typedef struct packed {
        logic  lock;
        logic  replay;
        t_word word;
    } t_chord;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SREAD,
        ST_SEVAL,
        ST_ALT,
        ST_DECIDE,
        ST_END,
        ST_DONE
    } t_state;

    // chord w against event ev; the any code in w matches all modifiers
    function automatic logic word_match(t_word w, t_word ev);
        logic low_eq;
        low_eq = (w.etype == ev.etype) && (w.key == ev.key) && (w.button == ev.button);
        return low_eq && ((w.mods == ANY_MODS) || (w.mods == ev.mods));
    endfunction

endpackage
`default_nettype wire

@@ rtl/hotkey_chain_matcher_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hotkey_chain_matcher_core
// hotkey slot table with chained chords, matched one slot at a time
// ----------------------------------------------------------------------------
// Every accepted item yields exactly one result transfer. Load items (chord
// write, slot info, chain abort) go straight from idle to the done state. An
// event walks all slots in order through the slot memory: an enabled slot that
// takes part goes through a read step, an evaluate step, MAX_ALTS steps in
// the chord memory and a write-back step; a disabled slot, or one that the chain
// state skips, takes only the read and evaluate steps. An event that drops an
// active chain (abort chord, or no slot kept it going) runs a second pass. A
// pass ends early when a plain hotkey fires. The chord memory port and the slot
// memory port set this step order. No clearing pass is needed after reset.
module hotkey_chain_matcher_core
    import hkcm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // item channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_kind,
    input  wire  [3:0]  i_slot,
    input  wire  [1:0]  i_step,
    input  wire  [1:0]  i_alt,
    input  wire  [7:0]  i_event_type,
    input  wire  [31:0] i_key,
    input  wire  [7:0]  i_button,
    input  wire  [15:0] i_modifiers,
    input  wire  [1:0]  i_flags,
    input  wire  [2:0]  i_chain_length,
    input  wire  [7:0]  i_cycle_period,
    input  wire  [7:0]  i_cycle_delay,
    // result channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_fired,
    output logic [3:0]  o_fired_slot,
    output logic        o_replay,
    output logic        o_chain_active,
    output logic        o_chain_locked,
    // configuration write channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int AW = (MAX_ALTS > 1) ? $clog2(MAX_ALTS) : 1;
    localparam int NW = $clog2(MAX_STEPS + 1);
    localparam int CW = SW + PW + AW;
    localparam int CDEPTH = 2 ** CW;
    localparam int SDEPTH = 2 ** SW;

    // abort chord registers
    t_word r_abort;

    // state
    t_state r_state, n_state;
    logic [SW-1:0] r_slot, n_slot;
    logic [AW-1:0] r_alt, n_alt;
    logic          r_pass, n_pass;
    logic          r_active, n_active;
    logic          r_locks, n_locks;
    logic          r_rep, n_rep;
    logic          r_res_v, n_res_v;
    logic [SW-1:0] r_res, n_res;
    logic          r_fire_v, n_fire_v;
    logic [SW-1:0] r_fire, n_fire;
    logic          r_chain, n_chain;
    logic          r_lock, n_lock;
    logic          r_lead_v, n_lead_v;
    logic          r_lead_rep, n_lead_rep;
    logic          r_lead_lock, n_lead_lock;
    logic [7:0]    r_lead_et, n_lead_et;
    logic          r_match, n_match;
    logic [NW-1:0] r_n, n_n;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_per, n_per;
    logic [7:0]    r_dly, n_dly;
    logic          r_tail, n_tail;
    t_word         r_ev;
    logic          r_ovalid;
    logic          r_ofired, r_orep, r_ochain, r_olock;
    logic [3:0]    r_oslot;

    // chord memory and its valid flops
    t_chord        cmem [CDEPTH];
    t_chord        r_cd;
    logic [CDEPTH-1:0] r_cvalid;
    logic          c_we;
    logic [CW-1:0] c_waddr, c_raddr;

    // slot memory, one entry per slot, with per-slot valid flops
    logic [NW-1:0] s_cnt_mem [SDEPTH];
    logic [PW-1:0] s_pos_mem [SDEPTH];
    logic [7:0]    s_per_mem [SDEPTH];
    logic [7:0]    s_dly_mem [SDEPTH];
    logic [NW-1:0] r_rd_cnt;
    logic [PW-1:0] r_rd_pos;
    logic [7:0]    r_rd_per, r_rd_dly;
    logic [SDEPTH-1:0] r_slot_v, r_pos_v;
    logic          s_we, s_pos_clr;
    logic [SW-1:0] s_waddr;
    logic [NW-1:0] s_wcnt;
    logic [PW-1:0] s_wpos;
    logic [7:0]    s_wper, s_wdly;

    logic in_xfer, out_xfer, load_ok, chord_ok;
    logic [NW-1:0] sat_len;
    logic [NW-1:0] ev_n;
    logic [PW-1:0] ev_pos, ev_posc;
    logic          ev_tail;
    logic          alt_v;
    t_word         in_word;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_ovalid && !i_out_stall;

    assign in_word  = '{mods: i_modifiers, button: i_button, key: i_key, etype: i_event_type};
    assign load_ok  = (32'(i_slot) < SLOTS);
    assign chord_ok = load_ok && (32'(i_step) < MAX_STEPS) && (32'(i_alt) < MAX_ALTS);
    assign sat_len  = (32'(i_chain_length) > MAX_STEPS) ? NW'(MAX_STEPS) : NW'(i_chain_length);

    // slot entry as read, masked by valid flops
    assign ev_n    = r_slot_v[r_slot] ? r_rd_cnt : '0;
    assign ev_pos  = (r_slot_v[r_slot] && r_pos_v[r_slot]) ? r_rd_pos : '0;
    assign ev_posc = (32'(ev_pos) >= 32'(ev_n)) ? '0 : ev_pos;
    assign ev_tail = (32'(ev_posc) + 32'd1 == 32'(ev_n));
    assign alt_v   = r_cvalid[{r_slot, r_pos, r_alt}];

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abort <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ABORT_TYPE: r_abort.etype  <= i_cfg_data[7:0];
                CFG_ABORT_KEY:  r_abort.key    <= i_cfg_data;
                CFG_ABORT_BTN:  r_abort.button <= i_cfg_data[7:0];
                CFG_ABORT_MODS: r_abort.mods   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // chord memory
    assign c_we    = in_xfer && (i_kind == KIND_CHORD) && chord_ok;
    assign c_waddr = {SW'(i_slot), PW'(i_step), AW'(i_alt)};

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            cmem[c_waddr] <= '{lock: i_flags[1], replay: i_flags[0], word: in_word};
        end
        r_cd <= cmem[c_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
        end else if (c_we) begin
            r_cvalid[c_waddr] <= 1'b1;
        end
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            s_cnt_mem[s_waddr] <= s_wcnt;
            s_pos_mem[s_waddr] <= s_wpos;
            s_per_mem[s_waddr] <= s_wper;
            s_dly_mem[s_waddr] <= s_wdly;
        end
        r_rd_cnt <= s_cnt_mem[r_slot];
        r_rd_pos <= s_pos_mem[r_slot];
        r_rd_per <= s_per_mem[r_slot];
        r_rd_dly <= s_dly_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_v <= '0;
            r_pos_v  <= '0;
        end else begin
            if (s_pos_clr) begin
                r_pos_v <= '0;
            end else if (s_we) begin
                r_pos_v[s_waddr] <= 1'b1;
            end
            if (in_xfer && (i_kind == KIND_INFO) && load_ok) begin
                r_slot_v[s_waddr] <= 1'b1;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_alt       = r_alt;
        n_pass      = r_pass;
        n_active    = r_active;
        n_locks     = r_locks;
        n_rep       = r_rep;
        n_res_v     = r_res_v;
        n_res       = r_res;
        n_fire_v    = r_fire_v;
        n_fire      = r_fire;
        n_chain     = r_chain;
        n_lock      = r_lock;
        n_lead_v    = r_lead_v;
        n_lead_rep  = r_lead_rep;
        n_lead_lock = r_lead_lock;
        n_lead_et   = r_lead_et;
        n_match     = r_match;
        n_n         = r_n;
        n_pos       = r_pos;
        n_per       = r_per;
        n_dly       = r_dly;
        n_tail      = r_tail;
        c_raddr     = {r_slot, r_pos, r_alt};
        s_we        = 1'b0;
        s_pos_clr   = 1'b0;
        s_waddr     = r_slot;
        s_wcnt      = r_n;
        s_wpos      = r_pos;
        s_wper      = r_per;
        s_wdly      = r_dly;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_fire_v = 1'b0;
                    n_fire   = '0;
                    n_rep    = 1'b0;
                    n_state  = ST_DONE;
                    case (i_kind)
                        KIND_INFO: begin
                            s_waddr = SW'(i_slot);
                            s_we    = load_ok;
                            s_wcnt  = sat_len;
                            s_wpos  = '0;
                            s_wper  = i_cycle_period;
                            s_wdly  = i_cycle_delay;
                        end
                        KIND_EVENT: begin
                            n_slot   = '0;
                            n_pass   = 1'b0;
                            n_active = 1'b0;
                            n_locks  = 1'b0;
                            n_res_v  = 1'b0;
                            n_state  = ST_SREAD;
                        end
                        KIND_ABORT: begin
                            s_pos_clr = 1'b1;
                            n_chain   = 1'b0;
                            n_lock    = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SREAD: begin
                n_state = ST_SEVAL;
            end
            ST_SEVAL: begin
                n_n      = ev_n;
                n_pos    = ev_posc;
                n_per    = r_slot_v[r_slot] ? r_rd_per : '0;
                n_dly    = r_slot_v[r_slot] ? r_rd_dly : '0;
                n_tail   = ev_tail;
                n_alt    = '0;
                n_lead_v = 1'b0;
                n_match  = 1'b0;
                c_raddr  = {r_slot, ev_posc, AW'(0)};
                if ((ev_n == '0) || (r_chain && ev_posc == '0) || (r_lock && !ev_tail)) begin
                    if (32'(r_slot) == SLOTS - 1) begin
                        n_state = ST_END;
                    end else begin
                        n_slot  = r_slot + SW'(1);
                        n_state = ST_SREAD;
                    end
                end else begin
                    n_state = ST_ALT;
                end
            end
            ST_ALT: begin
                c_raddr = {r_slot, r_pos, r_alt + AW'(1)};
                if (alt_v && !r_lead_v) begin
                    n_lead_v    = 1'b1;
                    n_lead_rep  = r_cd.replay;
                    n_lead_lock = r_cd.lock;
                    n_lead_et   = r_cd.word.etype;
                end
                if (alt_v && word_match(r_cd.word, r_ev)) begin
                    n_match = 1'b1;
                end
                if (32'(r_alt) == MAX_ALTS - 1) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_alt = r_alt + AW'(1);
                end
            end
            ST_DECIDE: begin
                if (32'(r_slot) == SLOTS - 1) begin
                    n_state = ST_END;
                end else begin
                    n_slot  = r_slot + SW'(1);
                    n_state = ST_SREAD;
                end
                if (r_match) begin
                    n_rep   = r_rep | r_lead_rep;
                    n_locks = r_locks | r_lead_lock;
                    if (r_tail) begin
                        if (r_per != '0) begin
                            // cycled hotkey: count down, fire on zero
                            s_we   = 1'b1;
                            s_wdly = (r_dly == '0) ? r_per - 8'd1 : r_dly - 8'd1;
                            if (r_dly == '0) begin
                                n_res_v = 1'b1;
                                n_res   = r_slot;
                            end
                        end else begin
                            // plain hotkey fires and ends the pass
                            n_fire_v = 1'b1;
                            n_fire   = r_slot;
                            n_state  = ST_DONE;
                            if (r_chain && !r_lock) begin
                                s_pos_clr = 1'b1;
                                n_chain   = 1'b0;
                                n_lock    = 1'b0;
                            end
                        end
                    end else begin
                        s_we     = 1'b1;
                        s_wpos   = r_pos + PW'(1);
                        n_active = 1'b1;
                    end
                end else if (r_chain) begin
                    if (!r_lock && r_lead_v && (r_lead_et == r_ev.etype)) begin
                        s_we   = 1'b1;
                        s_wpos = '0;
                    end else begin
                        n_active = 1'b1;
                    end
                end
            end
            ST_END: begin
                n_state = ST_DONE;
                if (r_res_v) begin
                    n_fire_v = 1'b1;
                    n_fire   = r_res;
                end else begin
                    n_fire_v = 1'b0;
                    if (r_locks) begin
                        n_lock = 1'b1;
                    end
                    if (!r_chain) begin
                        n_chain = r_active;
                    end else if (!r_active || word_match(r_abort, r_ev)) begin
                        s_pos_clr = 1'b1;
                        n_chain   = 1'b0;
                        n_lock    = 1'b0;
                        if (!r_pass) begin
                            // rerun the same event once
                            n_pass   = 1'b1;
                            n_slot   = '0;
                            n_active = 1'b0;
                            n_locks  = 1'b0;
                            n_res_v  = 1'b0;
                            n_state  = ST_SREAD;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_chain  <= 1'b0;
            r_lock   <= 1'b0;
            r_pass   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chain <= n_chain;
            r_lock  <= n_lock;
            r_pass  <= (n_state == ST_IDLE) ? 1'b0 : n_pass;
            if (r_state == ST_DONE && (!r_ovalid || !i_out_stall)) begin
                r_ovalid <= 1'b1;
            end else if (out_xfer) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_slot      <= n_slot;
        r_alt       <= n_alt;
        r_active    <= n_active;
        r_locks     <= n_locks;
        r_rep       <= n_rep;
        r_res_v     <= n_res_v;
        r_res       <= n_res;
        r_fire_v    <= n_fire_v;
        r_fire      <= n_fire;
        r_lead_v    <= n_lead_v;
        r_lead_rep  <= n_lead_rep;
        r_lead_lock <= n_lead_lock;
        r_lead_et   <= n_lead_et;
        r_match     <= n_match;
        r_n         <= n_n;
        r_pos       <= n_pos;
        r_per       <= n_per;
        r_dly       <= n_dly;
        r_tail      <= n_tail;
        if (in_xfer) begin
            r_ev <= in_word;
        end
        if (r_state == ST_DONE && (!r_ovalid || !i_out_stall)) begin
            r_ofired <= r_fire_v;
            r_oslot  <= r_fire_v ? 4'(r_fire) : 4'd0;
            r_orep   <= r_rep;
            r_ochain <= r_chain;
            r_olock  <= r_lock;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_fired        = r_ofired;
    assign o_fired_slot   = r_oslot;
    assign o_replay       = r_orep;
    assign o_chain_active = r_ochain;
    assign o_chain_locked = r_olock;

    // an accepted event always starts a slot walk
    a_event_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_kind == KIND_EVENT) |=> (r_state == ST_SREAD))
        else $error("event did not start slot walk");

    // the slot walk never runs past the last slot
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE || r_state == ST_SEVAL) |-> (32'(r_slot) < SLOTS))
        else $error("slot index out of range");

    // the alternative scan stays inside the step
    a_alt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALT) |-> (32'(r_alt) < MAX_ALTS))
        else $error("alternative index out of range");

    // rerun flag is only ever set while an event is in flight
    a_pass_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pass)
        else $error("rerun flag left set");

endmodule
`default_nettype wire
